FILE: rtl/bilinear_grid_upsampler_core_macros.svh
// assertion macros shared by the bilinear grid upsampler checkers
// no dependencies; expects i_clk and i_rst_n in the scope of each use
`ifndef BILINEAR_GRID_UPSAMPLER_CORE_MACROS_SVH
`define BILINEAR_GRID_UPSAMPLER_CORE_MACROS_SVH

// same-cycle implication, masked during reset
`define BGU_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bgu check failed");

// next-cycle implication, masked during reset
`define BGU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bgu check failed");

// condition that must hold in the cycle after a reset cycle
`define BGU_ASSERT_AFTER_RST(lbl, cons) \
    lbl: assert property (@(posedge i_clk) (!i_rst_n) |=> (cons)) \
        else $error("bgu reset check failed");

`endif

FILE: rtl/bgu_pkg.sv
// shared types and constants for the bilinear grid upsampler
// no dependencies; used by every module of the block but bgu_ram
package bgu_pkg;

    // field widths
    localparam int COORD_W     = 10;
    localparam int SAMPLE_W    = 16;
    localparam int FRAC_W      = 16;
    localparam int SRC_CFG_W   = 9;
    localparam int DST_CFG_W   = 11;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 11;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_SIDE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_SIDE = 1'b1;

    // reset values of the side registers
    localparam logic [SRC_CFG_W-1:0] SRC_SIDE_RST = 9'd256;
    localparam logic [DST_CFG_W-1:0] DST_SIDE_RST = 11'd1024;

    // action codes carried in tuser
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

FILE: rtl/bgu_ram.sv
// generic single-port ram with registered read
// no dependencies
module bgu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one access per cycle, write or read
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/bgu_div.sv
// restoring unsigned divider, one quotient bit per cycle
// depends on bgu_pkg for the status struct
module bgu_div #(
    parameter int NUM_W = 34,
    parameter int DEN_W = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [NUM_W-1:0]      i_num,
    input  logic [DEN_W-1:0]      i_den,
    output logic [NUM_W-1:0]      o_quo,
    output bgu_pkg::t_div_stat    o_stat
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_nq;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;

    // trial subtract of the divisor from the shifted remainder
    assign trial = {r_rem, r_nq[NUM_W-1]};
    assign fits  = (trial >= {1'b0, r_den});
    assign diff  = trial - {1'b0, r_den};

    // dividend bits leave at the top while quotient bits enter at the bottom
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_nq   <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
                r_cnt  <= CNT_W'(NUM_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_nq  <= {r_nq[NUM_W-2:0], fits};
                r_rem <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_quo       = r_nq;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

FILE: rtl/bilinear_grid_upsampler_core.sv
// top level of the bilinear grid upsampler: sequencer, shared multiplier, grid store
// depends on bgu_pkg, bgu_ram and bgu_div
//
// usage
//   s_axis carries one transaction per item: tuser is the action (load or query),
//   tdata holds col, row and sample_in. m_axis returns exactly one transaction
//   per item: tdata holds elevation_out, tuser holds range_error.
//   the side registers are written through i_cfg_we / i_cfg_addr / i_cfg_data;
//   the user must write them only while the block is idle; the block does not enforce it.
// sequence
//   a load, or an item with out-of-range coordinates, goes from idle straight to the
//   done state, which writes the output register once it is free and returns to idle. a
//   query computes two source positions on one bit-serial divider with N = 26 +
//   log2(MAX_SRC_SIDE) quotient bits each (34 at the default size), reads four
//   samples one per cycle from the single-port grid ram and runs two position and
//   three interpolation products through one shared multiplier before the done
//   state. s_axis_tready is high only while the sequencer is idle.
// reset and stalls
//   reset (synchronous, active low) returns the sequencer to idle, drops the
//   output valid and sets the sides to 256 and 1024. the grid ram is not cleared;
//   a sample must be loaded before it is read. a result waits in the output
//   register while m_axis_tready is low; the next item is still accepted, and
//   its result is held in the sequencer until the output register frees up.
module bilinear_grid_upsampler_core #(
    parameter int MAX_SRC_SIDE = 256,
    parameter int MAX_DST_SIDE = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [bgu_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  logic [bgu_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // input items
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [bgu_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // col[9:0], row[19:10], sample_in[35:20]
    input  logic                             s_axis_tuser,  // action[0]
    // result items
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [bgu_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,  // elevation_out[15:0]
    output logic                             m_axis_tuser   // range_error[0]
);

    localparam int SW    = (MAX_SRC_SIDE > 1) ? $clog2(MAX_SRC_SIDE) : 1;
    localparam int DW    = (MAX_DST_SIDE > 1) ? $clog2(MAX_DST_SIDE) : 1;
    localparam int AW    = $clog2(MAX_SRC_SIDE * MAX_SRC_SIDE);
    localparam int PW    = bgu_pkg::COORD_W + SW;
    localparam int NW    = PW + bgu_pkg::FRAC_W;
    localparam int SMP_W = bgu_pkg::SAMPLE_W;
    localparam int FW    = bgu_pkg::FRAC_W;

    // sequencer states
    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_MX   = 5'd1;
    localparam logic [4:0] ST_DX   = 5'd2;
    localparam logic [4:0] ST_WX   = 5'd3;
    localparam logic [4:0] ST_MY   = 5'd4;
    localparam logic [4:0] ST_DY   = 5'd5;
    localparam logic [4:0] ST_WY   = 5'd6;
    localparam logic [4:0] ST_RA   = 5'd7;
    localparam logic [4:0] ST_RB   = 5'd8;
    localparam logic [4:0] ST_RC   = 5'd9;
    localparam logic [4:0] ST_RD   = 5'd10;
    localparam logic [4:0] ST_RE   = 5'd11;
    localparam logic [4:0] ST_M1   = 5'd12;
    localparam logic [4:0] ST_M2   = 5'd13;
    localparam logic [4:0] ST_M3   = 5'd14;
    localparam logic [4:0] ST_M4   = 5'd15;
    localparam logic [4:0] ST_M5   = 5'd16;
    localparam logic [4:0] ST_RND  = 5'd17;
    localparam logic [4:0] ST_DONE = 5'd18;

    logic [4:0]                      r_state;
    logic [4:0]                      n_state;
    logic [bgu_pkg::SRC_CFG_W-1:0]   r_src_side;
    logic [bgu_pkg::DST_CFG_W-1:0]   r_dst_side;
    logic [SW-1:0]                   s_m1;
    logic [DW-1:0]                   d_m1;

    logic                            in_accept;
    logic                            in_action;
    logic [bgu_pkg::COORD_W-1:0]     in_col;
    logic [bgu_pkg::COORD_W-1:0]     in_row;
    logic [SMP_W-1:0]                in_sample;
    logic                            load_bad;
    logic                            query_bad;

    logic [bgu_pkg::COORD_W-1:0]     r_col;
    logic [bgu_pkg::COORD_W-1:0]     r_row;
    logic [SW-1:0]                   r_x0;
    logic [SW-1:0]                   r_y0;
    logic [FW-1:0]                   r_fx;
    logic [FW-1:0]                   r_fy;
    logic [SW-1:0]                   x1;
    logic [SW-1:0]                   y1;
    logic signed [SMP_W-1:0]         r_c00;
    logic signed [SMP_W-1:0]         r_c10;
    logic signed [SMP_W-1:0]         r_c01;
    logic signed [SMP_W-1:0]         r_c11;

    logic signed [32:0]              mul_a;
    logic signed [16:0]              mul_b;
    logic signed [49:0]              mul_p;
    logic signed [49:0]              r_prod;
    logic signed [32:0]              r_top;
    logic signed [32:0]              r_bot;
    logic signed [49:0]              r_acc;
    logic                            round_up;

    logic [SMP_W-1:0]                r_res;
    logic                            r_err;
    logic                            r_out_valid;
    logic [SMP_W-1:0]                r_out_elev;
    logic                            r_out_err;
    logic                            out_free;

    logic                            ram_en;
    logic                            ram_we;
    logic [AW-1:0]                   ram_addr;
    logic [SMP_W-1:0]                ram_rdata;

    logic                            div_start;
    logic [NW-1:0]                   div_num;
    logic [NW-1:0]                   div_quo;
    bgu_pkg::t_div_stat              div_stat;

    // flat grid address of a source sample
    function automatic logic [AW-1:0] grid_addr(input logic [SW-1:0] x, input logic [SW-1:0] y);
        return AW'(32'(y) * 32'(MAX_SRC_SIDE) + 32'(x));
    endfunction

    // input unpacking
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign in_action = s_axis_tuser;
    assign in_col    = s_axis_tdata[9:0];
    assign in_row    = s_axis_tdata[19:10];
    assign in_sample = s_axis_tdata[35:20];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_side <= bgu_pkg::SRC_SIDE_RST;
            r_dst_side <= bgu_pkg::DST_SIDE_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_addr == bgu_pkg::CFG_SRC_SIDE) begin
                r_src_side <= i_cfg_data[bgu_pkg::SRC_CFG_W-1:0];
            end else begin
                r_dst_side <= i_cfg_data;
            end
        end
    end

    // effective sides minus one, clamped to the supported range
    always_comb begin
        if (r_src_side < 9'd2) begin
            s_m1 = SW'(1);
        end else if (32'(r_src_side) > 32'(MAX_SRC_SIDE)) begin
            s_m1 = SW'(MAX_SRC_SIDE - 1);
        end else begin
            s_m1 = SW'(32'(r_src_side) - 32'd1);
        end
        if (r_dst_side < 11'd2) begin
            d_m1 = DW'(1);
        end else if (32'(r_dst_side) > 32'(MAX_DST_SIDE)) begin
            d_m1 = DW'(MAX_DST_SIDE - 1);
        end else begin
            d_m1 = DW'(32'(r_dst_side) - 32'd1);
        end
    end

    // coordinate range checks
    assign load_bad  = (32'(in_col) > 32'(s_m1)) || (32'(in_row) > 32'(s_m1));
    assign query_bad = (32'(in_col) > 32'(d_m1)) || (32'(in_row) > 32'(d_m1));

    // far neighbors, clamped at the last sample
    assign x1 = (r_x0 == s_m1) ? r_x0 : r_x0 + SW'(1);
    assign y1 = (r_y0 == s_m1) ? r_y0 : r_y0 + SW'(1);

    // shared multiplier operand select
    always_comb begin
        case (r_state)
            ST_MX: begin
                mul_a = 33'(r_col);
                mul_b = 17'(s_m1);
            end
            ST_MY: begin
                mul_a = 33'(r_row);
                mul_b = 17'(s_m1);
            end
            ST_M1: begin
                mul_a = 33'(r_c10) - 33'(r_c00);
                mul_b = 17'(r_fx);
            end
            ST_M2: begin
                mul_a = 33'(r_c11) - 33'(r_c01);
                mul_b = 17'(r_fx);
            end
            ST_M4: begin
                mul_a = r_bot - r_top;
                mul_b = 17'(r_fy);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = 50'(mul_a) * 50'(mul_b);

    // divider hookup: numerator is coord*(side-1) with 16 fraction bits (18.16 at the default size)
    assign div_num   = {r_prod[PW-1:0], {FW{1'b0}}};
    assign div_start = ((r_state == ST_DX) || (r_state == ST_DY)) && !div_stat.busy;

    bgu_div #(
        .NUM_W (NW),
        .DEN_W (DW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (d_m1),
        .o_quo   (div_quo),
        .o_stat  (div_stat)
    );

    // grid ram port: writes on load accept, neighbor reads on query
    always_comb begin
        ram_we = (r_state == ST_IDLE);
        ram_en = (r_state inside {ST_RA, ST_RB, ST_RC, ST_RD})
              || (in_accept && (in_action == bgu_pkg::ACT_LOAD) && !load_bad);
        case (r_state)
            ST_RA:   ram_addr = grid_addr(r_x0, r_y0);
            ST_RB:   ram_addr = grid_addr(x1, r_y0);
            ST_RC:   ram_addr = grid_addr(r_x0, y1);
            ST_RD:   ram_addr = grid_addr(x1, y1);
            default: ram_addr = grid_addr(SW'(in_col), SW'(in_row));
        endcase
    end

    bgu_ram #(
        .WIDTH (SMP_W),
        .DEPTH (MAX_SRC_SIDE * MAX_SRC_SIDE)
    ) u_grid (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (in_sample),
        .o_rdata (ram_rdata)
    );

    // truncation toward zero of acc / 2^32
    assign round_up = r_acc[49] && (r_acc[31:0] != 32'd0);
    assign out_free = !r_out_valid || m_axis_tready;

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    if ((in_action == bgu_pkg::ACT_QUERY) && !query_bad) begin
                        n_state = ST_MX;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_MX:  n_state = ST_DX;
            ST_DX:  n_state = ST_WX;
            ST_WX:  n_state = div_stat.done ? ST_MY : ST_WX;
            ST_MY:  n_state = ST_DY;
            ST_DY:  n_state = ST_WY;
            ST_WY:  n_state = div_stat.done ? ST_RA : ST_WY;
            ST_RA:  n_state = ST_RB;
            ST_RB:  n_state = ST_RC;
            ST_RC:  n_state = ST_RD;
            ST_RD:  n_state = ST_RE;
            ST_RE:  n_state = ST_M1;
            ST_M1:  n_state = ST_M2;
            ST_M2:  n_state = ST_M3;
            ST_M3:  n_state = ST_M4;
            ST_M4:  n_state = ST_M5;
            ST_M5:  n_state = ST_RND;
            ST_RND: n_state = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        case (r_state)
            ST_IDLE: begin
                r_col <= in_col;
                r_row <= in_row;
                r_res <= '0;
                r_err <= (in_action == bgu_pkg::ACT_LOAD) ? load_bad : query_bad;
            end
            ST_WX: begin
                r_x0 <= div_quo[SW+FW-1:FW];
                r_fx <= div_quo[FW-1:0];
            end
            ST_WY: begin
                r_y0 <= div_quo[SW+FW-1:FW];
                r_fy <= div_quo[FW-1:0];
            end
            ST_RB:  r_c00 <= ram_rdata;
            ST_RC:  r_c10 <= ram_rdata;
            ST_RD:  r_c01 <= ram_rdata;
            ST_RE:  r_c11 <= ram_rdata;
            ST_M2:  r_top <= {r_c00[SMP_W-1], r_c00, {FW{1'b0}}} + r_prod[32:0];
            ST_M3:  r_bot <= {r_c01[SMP_W-1], r_c01, {FW{1'b0}}} + r_prod[32:0];
            ST_M5:  r_acc <= {r_top[32], r_top, {FW{1'b0}}} + r_prod;
            ST_RND: r_res <= r_acc[47:32] + SMP_W'(round_up);
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_DONE) && out_free) begin
            r_out_valid <= 1'b1;
            r_out_elev  <= r_res;
            r_out_err   <= r_err;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_elev;
    assign m_axis_tuser  = r_out_err;

endmodule

FILE: rtl/bgu_checker.sv
// port-level assertions for the bilinear grid upsampler, bound to the top level
// depends on bgu_pkg and bilinear_grid_upsampler_core_macros.svh
`include "bilinear_grid_upsampler_core_macros.svh"

module bgu_port_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [bgu_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,  // elevation_out[15:0]
    input  logic                             m_axis_tuser   // range_error[0]
);

    // a stalled result holds its transaction
    `BGU_ASSERT_NEXT(a_stall_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // a flagged range error always carries a zero elevation
    `BGU_ASSERT_NOW(a_err_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 16'd0)

    // one item at a time: the sequencer leaves idle after every accept
    `BGU_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // reset leaves no result pending and the sequencer idle
    `BGU_ASSERT_AFTER_RST(a_reset_idle, !m_axis_tvalid && s_axis_tready)

endmodule

bind bilinear_grid_upsampler_core bgu_port_checker u_bgu_checker (.*);

FILE: dv/bgu_checker.sv
// result checker for the bilinear grid upsampler: tracks side settings and grid contents,
// predicts every result transaction and compares it field by field
// depends on bgu_pkg
`timescale 1ns / 100ps

module bgu_checker #(
    parameter int MAX_SRC_SIDE = 256,
    parameter int MAX_DST_SIDE = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [bgu_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  logic [bgu_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_in_valid,
    input  logic                             i_in_ready,
    input  logic [bgu_pkg::IN_TDATA_W-1:0]   i_in_data,   // col[9:0], row[19:10], sample_in[35:20]
    input  logic                             i_in_user,   // action[0]
    input  logic                             i_out_valid,
    input  logic                             i_out_ready,
    input  logic [bgu_pkg::OUT_TDATA_W-1:0]  i_out_data,  // elevation_out[15:0]
    input  logic                             i_out_user,  // range_error[0]
    output int                               o_pending,
    output int                               o_fail_count
);
    import bgu_pkg::*;

    typedef struct packed {
        logic [SAMPLE_W-1:0] elevation;
        logic                range_error;
    } t_grid_result;

    // shadow of the side registers and the sample grid
    logic [SRC_CFG_W-1:0] src_side_q;
    logic [DST_CFG_W-1:0] dst_side_q;
    logic [SAMPLE_W-1:0]  grid_mem [MAX_SRC_SIDE*MAX_SRC_SIDE];
    t_grid_result         elev_queue [$];
    int                   fails = 0;

    function automatic longint clamp_side(longint v, longint hi);
        if (v < 2) return 2;
        if (v > hi) return hi;
        return v;
    endfunction

    // 16.16 source position of a destination coordinate
    function automatic longint src_position(longint coord, longint s, longint d);
        return (coord * (s - 1) * 65536) / (d - 1);
    endfunction

    function automatic longint cell_value(longint x, longint y);
        return longint'($signed(grid_mem[y * MAX_SRC_SIDE + x]));
    endfunction

    // result of one input transaction; a load also updates the grid
    function automatic t_grid_result upsample_result(logic act, logic [COORD_W-1:0] c,
                                                     logic [COORD_W-1:0] r,
                                                     logic [SAMPLE_W-1:0] smp);
        t_grid_result res;
        longint s, d, px, py, x0, x1, y0, y1, fx, fy, top, bot, acc, q;
        s = clamp_side(longint'(src_side_q), MAX_SRC_SIDE);
        d = clamp_side(longint'(dst_side_q), MAX_DST_SIDE);
        res.elevation   = '0;
        res.range_error = 1'b0;
        if (act == ACT_LOAD) begin
            if (longint'(c) >= s || longint'(r) >= s) begin
                res.range_error = 1'b1;
            end else begin
                grid_mem[longint'(r) * MAX_SRC_SIDE + longint'(c)] = smp;
            end
        end else if (longint'(c) >= d || longint'(r) >= d) begin
            res.range_error = 1'b1;
        end else begin
            px = src_position(longint'(c), s, d);
            py = src_position(longint'(r), s, d);
            x0 = px >> 16;
            y0 = py >> 16;
            fx = px & 65535;
            fy = py & 65535;
            if (x0 > s - 1) x0 = s - 1;
            if (y0 > s - 1) y0 = s - 1;
            // far neighbor stays on the last sample at the edge
            x1 = (x0 + 1 < s) ? x0 + 1 : s - 1;
            y1 = (y0 + 1 < s) ? y0 + 1 : s - 1;
            top = cell_value(x0, y0) * (65536 - fx) + cell_value(x1, y0) * fx;
            bot = cell_value(x0, y1) * (65536 - fx) + cell_value(x1, y1) * fx;
            acc = top * (65536 - fy) + bot * fy;
            // signed division truncates toward zero
            q = acc / 64'sh1_0000_0000;
            res.elevation = q[SAMPLE_W-1:0];
        end
        return res;
    endfunction

    function automatic void note_fail(string what, logic [SAMPLE_W-1:0] want,
                                      logic [SAMPLE_W-1:0] got);
        fails++;
        $display("%0t: %s mismatch, expected %h got %h", $time, what, want, got);
    endfunction

    // watch both channels and the config port
    always @(posedge i_clk) begin : watch
        t_grid_result want;
        t_grid_result got;
        if (!i_rst_n) begin
            src_side_q = SRC_SIDE_RST;
            dst_side_q = DST_SIDE_RST;
            elev_queue.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_addr == CFG_SRC_SIDE)
                    src_side_q = i_cfg_data[SRC_CFG_W-1:0];
                else if (i_cfg_addr == CFG_DST_SIDE)
                    dst_side_q = i_cfg_data[DST_CFG_W-1:0];
            end
            // result transaction against the oldest expectation
            if (i_out_valid && i_out_ready) begin
                got.elevation   = i_out_data[SAMPLE_W-1:0];
                got.range_error = i_out_user;
                if (elev_queue.size() == 0) begin
                    fails++;
                    $display("%0t: result with none expected, expected none got %h/%b",
                             $time, got.elevation, got.range_error);
                end else begin
                    want = elev_queue.pop_front();
                    if (got.elevation !== want.elevation)
                        note_fail("elevation_out", want.elevation, got.elevation);
                    if (got.range_error !== want.range_error)
                        note_fail("range_error", SAMPLE_W'(want.range_error),
                                  SAMPLE_W'(got.range_error));
                end
            end
            // input transaction
            if (i_in_valid && i_in_ready)
                elev_queue.push_back(upsample_result(i_in_user,
                    i_in_data[COORD_W-1:0],
                    i_in_data[2*COORD_W-1:COORD_W],
                    i_in_data[2*COORD_W+SAMPLE_W-1:2*COORD_W]));
        end
        o_pending    <= elev_queue.size();
        o_fail_count <= fails;
    end

endmodule

FILE: dv/tb.sv
// top of the bilinear grid upsampler testbench: clock, reset, stimulus, stalls, verdict
// depends on bgu_pkg, bilinear_grid_upsampler_core and bgu_checker
`timescale 1ns / 100ps

module tb;
    import bgu_pkg::*;

    localparam int MAX_SRC = 256;
    localparam int MAX_DST = 1024;
    localparam int ITEM_TARGET = 950;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [CFG_IDX_W-1:0]    i_cfg_addr;
    logic [CFG_DATA_W-1:0]   i_cfg_data;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata;   // col[9:0], row[19:10], sample_in[35:20]
    logic                    s_axis_tuser;   // action[0]
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;   // elevation_out[15:0]
    logic                    m_axis_tuser;   // range_error[0]
    int                      pending;
    int                      fail_count;

    // stimulus-side view of the grid and sides
    bit cell_loaded [MAX_SRC*MAX_SRC];
    int cur_src;
    int cur_dst;
    int items_sent;
    int burst_left;

    bilinear_grid_upsampler_core #(
        .MAX_SRC_SIDE(MAX_SRC),
        .MAX_DST_SIDE(MAX_DST)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    bgu_checker #(
        .MAX_SRC_SIDE(MAX_SRC),
        .MAX_DST_SIDE(MAX_DST)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (s_axis_tvalid),
        .i_in_ready  (s_axis_tready),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .i_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_out_data  (m_axis_tdata),
        .i_out_user  (m_axis_tuser),
        .o_pending   (pending),
        .o_fail_count(fail_count)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #20_000_000;
        $display("bilinear_grid_upsampler_core verification failed");
        $finish;
    end

    // receiver stalls: changing patterns plus a long hold-off now and then
    initial begin : rx_stall
        int cyc_cnt;
        int hold_cnt;
        int stall_mode;
        int mode_cnt;
        cyc_cnt    = 0;
        hold_cnt   = 0;
        stall_mode = 0;
        mode_cnt   = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            cyc_cnt++;
            if (cyc_cnt % 4000 == 0)
                hold_cnt = 300;
            if (mode_cnt == 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_cnt   = $urandom_range(50, 300);
            end
            mode_cnt--;
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_axis_tready <= 1'b0;
            end else begin
                case (stall_mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= 1'($urandom_range(0, 1));
                    2: m_axis_tready <= ($urandom_range(0, 5) == 0);
                    default: m_axis_tready <= cyc_cnt[0];
                endcase
            end
        end
    end

    function automatic int side_clamp(int v, int hi);
        if (v < 2) return 2;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // in-range coordinate, biased toward the edges
    function automatic int pick_coord(int side);
        case ($urandom_range(0, 7))
            0: return 0;
            1: return side - 1;
            default: return $urandom_range(0, side - 1);
        endcase
    endfunction

    // near and far source index that a destination coordinate reads
    function automatic void src_span(input int coord, output int lo, output int hi);
        longint pos;
        pos = (longint'(coord) * (cur_src - 1) * 65536) / (cur_dst - 1);
        lo  = int'(pos >> 16);
        if (lo > cur_src - 1) lo = cur_src - 1;
        hi = (lo + 1 < cur_src) ? lo + 1 : cur_src - 1;
    endfunction

    // one input transaction, with burst and gap pacing
    task automatic push_item(input logic act, input int c, input int r,
                             input logic [SAMPLE_W-1:0] smp);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {{(IN_TDATA_W-SAMPLE_W-2*COORD_W){1'b0}}, smp,
                          COORD_W'(r), COORD_W'(c)};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 10);
        end
    endtask

    task automatic load_at(input int c, input int r, input logic [SAMPLE_W-1:0] smp);
        push_item(ACT_LOAD, c, r, smp);
        if (c < cur_src && r < cur_src)
            cell_loaded[r * MAX_SRC + c] = 1'b1;
    endtask

    task automatic fill_cell(input int x, input int y);
        if (!cell_loaded[y * MAX_SRC + x])
            load_at(x, y, pick_sample());
    endtask

    // query, preceded by loads of any neighbor not yet written
    task automatic query_at(input int c, input int r);
        int x0, x1, y0, y1;
        if (c < cur_dst && r < cur_dst) begin
            src_span(c, x0, x1);
            src_span(r, y0, y1);
            fill_cell(x0, y0);
            fill_cell(x1, y0);
            fill_cell(x0, y1);
            fill_cell(x1, y1);
        end
        push_item(ACT_QUERY, c, r, pick_sample());
    endtask

    // wait until every result is back and the block is idle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_sides(input logic [CFG_DATA_W-1:0] src_raw,
                             input logic [CFG_DATA_W-1:0] dst_raw);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= CFG_SRC_SIDE;
        i_cfg_data <= src_raw;
        @(posedge i_clk);
        i_cfg_addr <= CFG_DST_SIDE;
        i_cfg_data <= dst_raw;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_src = side_clamp(int'(src_raw[SRC_CFG_W-1:0]), MAX_SRC);
        cur_dst = side_clamp(int'(dst_raw), MAX_DST);
    endtask

    // random mix: mostly well-formed loads and queries, some out-of-range noise
    task automatic random_items(input int n);
        int start;
        int pick;
        start = items_sent;
        while (items_sent - start < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
                load_at(pick_coord(cur_src), pick_coord(cur_src), pick_sample());
            else if (pick < 38)
                load_at($urandom_range(0, 1023), $urandom_range(0, 1023), pick_sample());
            else if (pick < 92)
                query_at(pick_coord(cur_dst), pick_coord(cur_dst));
            else
                query_at($urandom_range(0, 1023), $urandom_range(0, 1023));
        end
    endtask

    // stimulus and verdict
    initial begin : stimulus
        int phase;
        logic [CFG_DATA_W-1:0] src_raw;
        logic [CFG_DATA_W-1:0] dst_raw;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_addr    <= CFG_SRC_SIDE;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= ACT_LOAD;
        cur_src    = int'(SRC_SIDE_RST);
        cur_dst    = int'(DST_SIDE_RST);
        items_sent = 0;
        burst_left = $urandom_range(1, 10);
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // default sides: extreme samples, corners, out-of-range loads
        load_at(0, 0, 16'h8000);
        load_at(1, 0, 16'h7FFF);
        load_at(0, 1, 16'h7FFF);
        load_at(1, 1, 16'h8000);
        load_at(255, 255, 16'h7FFF);
        load_at(256, 0, 16'h1234);
        load_at(1023, 1023, 16'hFFFF);
        query_at(0, 0);
        query_at(1, 1);
        query_at(1023, 1023);
        query_at(1023, 0);
        query_at(512, 511);

        // smallest grids on both sides, queries past the edge
        set_sides(11'd2, 11'd2);
        load_at(1, 1, 16'h7FFF);
        query_at(0, 0);
        query_at(1, 1);
        query_at(2, 0);
        query_at(1023, 1023);
        load_at(2, 1, 16'h5A5A);

        // smallest source spread over the largest destination
        set_sides(11'd2, 11'd1024);
        query_at(511, 511);
        query_at(1023, 512);

        // largest source squeezed into the smallest destination
        set_sides(11'd256, 11'd2);
        query_at(1, 1);
        query_at(0, 1);

        // random phases, first ones pinned to clamped and wide settings
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            case (phase)
                0: begin src_raw = 11'd0;   dst_raw = 11'd1;   end
                1: begin src_raw = 11'h7FF; dst_raw = 11'h7FF; end
                2: begin src_raw = 11'd3;   dst_raw = 11'd1023; end
                3: begin src_raw = 11'h500; dst_raw = 11'h400; end
                4: begin src_raw = 11'd16;  dst_raw = 11'd5;   end
                default: begin
                    case ($urandom_range(0, 2))
                        0: src_raw = CFG_DATA_W'($urandom_range(2, 16));
                        1: src_raw = CFG_DATA_W'($urandom_range(0, 511));
                        default: src_raw = CFG_DATA_W'($urandom);
                    endcase
                    case ($urandom_range(0, 2))
                        0: dst_raw = CFG_DATA_W'($urandom_range(2, 64));
                        1: dst_raw = CFG_DATA_W'($urandom_range(0, 1100));
                        default: dst_raw = CFG_DATA_W'($urandom);
                    endcase
                end
            endcase
            set_sides(src_raw, dst_raw);
            random_items(80);
            phase++;
        end

        drain();
        repeat (120) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("bilinear_grid_upsampler_core verification clean");
        else
            $display("bilinear_grid_upsampler_core verification failed");
        $finish;
    end

endmodule
